### hdl/ks_pkg.sv
// shared types, constants and the decay table of the kinetic scroll engine
package ks_pkg;

	// fixed-point format and table size
	localparam int FRAC_BITS         = 8;
	localparam int DECAY_TABLE_DEPTH = 256;
	localparam int IDX_W             = $clog2(DECAY_TABLE_DEPTH);

	// field widths
	localparam int OFF_W  = 24;
	localparam int VEL_W  = 25;
	localparam int Y_W    = 10;
	localparam int DT_W   = 16;
	localparam int CFG_W  = 16;
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;

	// datapath widths
	localparam int DQ_W      = Y_W + 1 + FRAC_BITS;
	localparam int DIV_W     = Y_W + DT_W + FRAC_BITS + 1;
	localparam int DIV_CNT_W = $clog2(DIV_W);
	localparam int MUL_A_W   = VEL_W;
	localparam int MUL_B_W   = DT_W + 1;
	localparam int MUL_P_W   = MUL_A_W + MUL_B_W;
	localparam int RND_W     = MUL_P_W - 16;
	localparam int SUM_W     = RND_W + 2;
	localparam int MAXF_W    = CFG_W + FRAC_BITS;
	localparam int GAIN_W    = DT_W + 4;

	// scaling constants
	localparam logic [DT_W-1:0]    DT_DEFAULT  = 16'd1092;
	localparam logic [MUL_B_W-1:0] RUBBER_Q16  = 17'd22938;
	localparam logic [MUL_B_W-1:0] ONE_Q16     = 17'd65536;
	localparam int                 SPRING_GAIN = 12;
	localparam int                 MIN_SPEED   = 8 << FRAC_BITS;
	localparam int                 SNAP_DIST   = 1 << (FRAC_BITS - 1);

	// saturation limits
	localparam logic signed [OFF_W-1:0] OFF_MAX = {1'b0, {(OFF_W-1){1'b1}}};
	localparam logic signed [OFF_W-1:0] OFF_MIN = {1'b1, {(OFF_W-1){1'b0}}};
	localparam logic signed [VEL_W-1:0] VEL_MAX = {1'b0, {(VEL_W-1){1'b1}}};
	localparam logic signed [VEL_W-1:0] VEL_MIN = {1'b1, {(VEL_W-1){1'b0}}};

	// register indexes
	localparam logic REG_CONTENT_HEIGHT = 1'b0;
	localparam logic REG_VIEW_HEIGHT    = 1'b1;

	// decay table type: exp(-4*i/depth) in Q0.16
	typedef logic [DECAY_TABLE_DEPTH-1:0][15:0] decay_tab_t;

	// table built at elaboration from a 7-term series for exp(-4/depth) in Q0.32
	function automatic decay_tab_t build_decay();
		logic [63:0] x;
		logic [63:0] term;
		logic [63:0] r;
		logic [63:0] p;
		logic [63:0] e;
		decay_tab_t  tab;
		x    = (64'd4 << 32) / DECAY_TABLE_DEPTH;
		term = 64'd1 << 32;
		r    = 64'd1 << 32;
		p    = 64'd1 << 32;
		term = (term * x) >> 32;
		r    = r - term;
		term = ((term * x) >> 32) / 2;
		r    = r + term;
		term = ((term * x) >> 32) / 3;
		r    = r - term;
		term = ((term * x) >> 32) / 4;
		r    = r + term;
		term = ((term * x) >> 32) / 5;
		r    = r - term;
		term = ((term * x) >> 32) / 6;
		r    = r + term;
		for (int i = 0; i < DECAY_TABLE_DEPTH; i++) begin
			e = (p + 64'd32768) >> 16;
			tab[i] = (e > 64'd65535) ? 16'hFFFF : e[15:0];
			p = (p * r + (64'd1 << 31)) >> 32;
		end
		return tab;
	endfunction

	localparam decay_tab_t DECAY_ROM = build_decay();

	// datapath operations
	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_PRESS,
		OP_DRAG_CHK,
		OP_MUL,
		OP_RUB_FIN,
		OP_DRAG_ADD,
		OP_DIV_STEP,
		OP_DIV_FIN,
		OP_GLIDE_OFF,
		OP_GLIDE_VEL,
		OP_VEL_ZERO,
		OP_SPR_FIN
	} ks_op_t;

	// multiplier operand selection
	typedef enum logic [1:0] {
		MSEL_RUB,
		MSEL_GOFF,
		MSEL_GVEL,
		MSEL_SPR
	} ks_msel_t;

	// sequencer states
	typedef enum logic [4:0] {
		ST_IDLE,
		ST_PRESS,
		ST_DRAG_CHK,
		ST_DRAG_SEL,
		ST_RUB_MUL,
		ST_RUB_FIN,
		ST_DRAG_ADD,
		ST_DIV,
		ST_DIV_FIN,
		ST_GLIDE_CHK,
		ST_GOFF_MUL,
		ST_GOFF_FIN,
		ST_GVEL_MUL,
		ST_GVEL_FIN,
		ST_SPR_CHK,
		ST_SPR_MUL,
		ST_SPR_FIN,
		ST_DONE
	} ks_state_t;

	typedef struct packed {
		ks_op_t   op;
		ks_msel_t msel;
	} ks_cmd_t;

	typedef struct packed {
		logic dragging;
		logic go_drag;
		logic rubber;
		logic delta_zero;
		logic div_last;
		logic glide;
		logic under;
		logic over;
	} ks_sts_t;

endpackage

### hdl/ks_dp.sv
// datapath of the kinetic scroll engine: state, shared multiplier and serial divider
module ks_dp import ks_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  ks_cmd_t                 cmd,
	output ks_sts_t                 sts,
	input  logic                    touch_down,
	input  logic                    touch_pressed,
	input  logic [Y_W-1:0]          touch_y,
	input  logic                    owns_touch,
	input  logic [DT_W-1:0]         frame_time,
	input  logic [CFG_W-1:0]        content_height,
	input  logic [CFG_W-1:0]        view_height,
	output logic signed [OFF_W-1:0] offset,
	output logic signed [VEL_W-1:0] velocity,
	output logic                    dragging
);

	// scroll state
	logic                    dragging_q;
	logic [Y_W-1:0]          last_y_q;
	logic signed [OFF_W-1:0] offset_q;
	logic signed [VEL_W-1:0] velocity_q;
	logic                    go_q;
	logic                    rub_q;
	logic [DIV_CNT_W-1:0]    div_cnt_q;

	// per-frame payload
	logic                    down_q;
	logic                    pressed_q;
	logic                    owns_q;
	logic [Y_W-1:0]          ty_q;
	logic [DT_W-1:0]         dt_q;
	logic [MUL_B_W-1:0]      gain_q;
	logic signed [OFF_W-1:0] maxq_q;
	logic [15:0]             decay_q;
	logic signed [Y_W:0]     delta_q;
	logic signed [DQ_W-1:0]  dq_q;
	logic [MUL_P_W-1:0]      mul_p_q;
	logic                    mul_neg_q;
	logic [DT_W-1:0]         div_rem_q;
	logic [DIV_W-1:0]        div_quo_q;
	logic                    div_neg_q;

	// combinational helpers
	logic [DT_W-1:0]         dt_eff;
	logic [GAIN_W-1:0]       gain_full;
	logic [MUL_B_W-1:0]      gain_eff;
	logic [31:0]             idx_full;
	logic [IDX_W-1:0]        idx;
	logic signed [CFG_W:0]   range_d;
	logic [MAXF_W-1:0]       maxq_full;
	logic signed [OFF_W-1:0] maxq_eff;
	logic signed [Y_W:0]     delta_c;
	logic                    rub_c;
	logic [DQ_W-1:0]         dq_mag;
	logic [VEL_W-1:0]        vel_mag;
	logic [OFF_W-1:0]        under_mag;
	logic [OFF_W-1:0]        over_mag;
	logic [Y_W:0]            delta_mag;
	logic [MUL_A_W-1:0]      mul_a;
	logic [MUL_B_W-1:0]      mul_b;
	logic                    mul_neg;
	logic [RND_W-1:0]        rnd_mag;
	logic [SUM_W-1:0]        rnd_u;
	logic signed [SUM_W-1:0] rnd_s;
	logic signed [SUM_W-1:0] off_ext;
	logic signed [SUM_W-1:0] glide_sum;
	logic signed [SUM_W-1:0] drag_sum;
	logic signed [OFF_W-1:0] spr_off;
	logic signed [OFF_W-1:0] spr_target;
	logic signed [OFF_W:0]   snap_d;
	logic [OFF_W:0]          snap_abs;
	logic signed [OFF_W-1:0] spr_final;
	logic [DT_W:0]           div_shift;
	logic                    div_ge;
	logic [DT_W:0]           div_sub;
	logic [DIV_W-1:0]        div_init;
	logic signed [VEL_W-1:0] div_vel;

	localparam logic [DIV_W-1:0] VEL_POS_LIM = DIV_W'($unsigned(VEL_MAX));
	localparam logic [DIV_W-1:0] VEL_NEG_LIM = VEL_POS_LIM + 1'b1;

	function automatic logic signed [OFF_W-1:0] sat_off(input logic signed [SUM_W-1:0] v);
		if (v > SUM_W'(OFF_MAX))
			return OFF_MAX;
		else if (v < SUM_W'(OFF_MIN))
			return OFF_MIN;
		else
			return v[OFF_W-1:0];
	endfunction

	function automatic logic signed [VEL_W-1:0] sat_vel(input logic signed [SUM_W-1:0] v);
		if (v > SUM_W'(VEL_MAX))
			return VEL_MAX;
		else if (v < SUM_W'(VEL_MIN))
			return VEL_MIN;
		else
			return v[VEL_W-1:0];
	endfunction

	// frame time, spring gain, decay index and scroll limit
	always_comb begin
		dt_eff    = (frame_time == '0) ? DT_DEFAULT : frame_time;
		gain_full = GAIN_W'(dt_eff) * GAIN_W'(SPRING_GAIN);
		gain_eff  = (gain_full > GAIN_W'(ONE_Q16)) ? ONE_Q16 : gain_full[MUL_B_W-1:0];
		idx_full  = (32'(dt_eff) * 32'(DECAY_TABLE_DEPTH)) >> 16;
		idx       = (idx_full >= 32'(DECAY_TABLE_DEPTH)) ? IDX_W'(DECAY_TABLE_DEPTH - 1)
		                                                 : idx_full[IDX_W-1:0];
		range_d   = $signed({1'b0, content_height}) - $signed({1'b0, view_height});
		maxq_full = range_d[CFG_W] ? '0 : (MAXF_W'(range_d[CFG_W-1:0]) << FRAC_BITS);
		maxq_eff  = (maxq_full > MAXF_W'($unsigned(OFF_MAX))) ? OFF_MAX
		                                                      : maxq_full[OFF_W-1:0];
	end

	// drag delta and rubber-band condition
	assign delta_c = $signed({1'b0, last_y_q}) - $signed({1'b0, ty_q});
	assign rub_c   = (offset_q[OFF_W-1] && delta_c[Y_W])
	              || ((offset_q > maxq_q) && !delta_c[Y_W] && (delta_c != '0));

	// magnitudes for the shared multiplier and the divider
	assign dq_mag    = dq_q[DQ_W-1] ? (~dq_q + 1'b1) : dq_q;
	assign vel_mag   = velocity_q[VEL_W-1] ? (~velocity_q + 1'b1) : velocity_q;
	assign under_mag = ~offset_q + 1'b1;
	assign over_mag  = offset_q - maxq_q;
	assign delta_mag = delta_q[Y_W] ? (~delta_q + 1'b1) : delta_q;

	// multiplier operand select
	always_comb begin
		mul_a   = '0;
		mul_b   = '0;
		mul_neg = 1'b0;
		case (cmd.msel)
			MSEL_RUB: begin
				mul_a   = MUL_A_W'(dq_mag);
				mul_b   = RUBBER_Q16;
				mul_neg = dq_q[DQ_W-1];
			end
			MSEL_GOFF: begin
				mul_a   = MUL_A_W'(vel_mag);
				mul_b   = MUL_B_W'(dt_q);
				mul_neg = velocity_q[VEL_W-1];
			end
			MSEL_GVEL: begin
				mul_a   = MUL_A_W'(vel_mag);
				mul_b   = MUL_B_W'(decay_q);
				mul_neg = velocity_q[VEL_W-1];
			end
			MSEL_SPR: begin
				mul_b = gain_q;
				if (offset_q[OFF_W-1]) begin
					mul_a   = MUL_A_W'(under_mag);
					mul_neg = 1'b0;
				end else begin
					mul_a   = MUL_A_W'(over_mag);
					mul_neg = 1'b1;
				end
			end
			default: begin
				mul_a   = '0;
			end
		endcase
	end

	// rounded Q0.16 product, ties away from zero
	always_comb begin
		rnd_mag   = RND_W'((mul_p_q + MUL_P_W'(32768)) >> 16);
		rnd_u     = SUM_W'(rnd_mag);
		rnd_s     = mul_neg_q ? -$signed(rnd_u) : $signed(rnd_u);
		off_ext   = SUM_W'(offset_q);
		glide_sum = off_ext + rnd_s;
		drag_sum  = off_ext + SUM_W'(dq_q);
	end

	// spring step with snap to the edge
	always_comb begin
		spr_off    = sat_off(glide_sum);
		spr_target = offset_q[OFF_W-1] ? '0 : maxq_q;
		snap_d     = (OFF_W+1)'(spr_off) - (OFF_W+1)'(spr_target);
		snap_abs   = snap_d[OFF_W] ? (~snap_d + 1'b1) : snap_d;
		spr_final  = (snap_abs < (OFF_W+1)'(SNAP_DIST)) ? spr_target : spr_off;
	end

	// restoring divider step and final velocity
	always_comb begin
		div_shift = {div_rem_q, div_quo_q[DIV_W-1]};
		div_ge    = div_shift >= {1'b0, dt_q};
		div_sub   = div_shift - {1'b0, dt_q};
		div_init  = (DIV_W'(delta_mag) << (DT_W + FRAC_BITS)) + DIV_W'(dt_q >> 1);
		if (div_neg_q)
			div_vel = (div_quo_q > VEL_NEG_LIM) ? VEL_MIN : -$signed(div_quo_q[VEL_W-1:0]);
		else
			div_vel = (div_quo_q > VEL_POS_LIM) ? VEL_MAX : $signed(div_quo_q[VEL_W-1:0]);
	end

	// scroll state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dragging_q <= 1'b0;
			last_y_q   <= '0;
			offset_q   <= '0;
			velocity_q <= '0;
			go_q       <= 1'b0;
			rub_q      <= 1'b0;
			div_cnt_q  <= '0;
		end else begin
			case (cmd.op)
				OP_PRESS: begin
					if (owns_q && pressed_q) begin
						dragging_q <= 1'b1;
						velocity_q <= '0;
						last_y_q   <= ty_q;
					end
				end
				OP_DRAG_CHK: begin
					if (dragging_q && down_q) begin
						last_y_q <= ty_q;
						go_q     <= 1'b1;
						rub_q    <= rub_c;
					end else begin
						dragging_q <= 1'b0;
						go_q       <= 1'b0;
						rub_q      <= 1'b0;
					end
				end
				OP_DRAG_ADD: begin
					offset_q  <= sat_off(drag_sum);
					div_cnt_q <= DIV_CNT_W'(DIV_W - 1);
					if (delta_q == '0)
						velocity_q <= '0;
				end
				OP_DIV_STEP: begin
					div_cnt_q <= div_cnt_q - 1'b1;
				end
				OP_DIV_FIN: begin
					velocity_q <= div_vel;
				end
				OP_GLIDE_OFF: begin
					offset_q <= sat_off(glide_sum);
				end
				OP_GLIDE_VEL: begin
					velocity_q <= sat_vel(rnd_s);
				end
				OP_VEL_ZERO: begin
					velocity_q <= '0;
				end
				OP_SPR_FIN: begin
					offset_q   <= spr_final;
					velocity_q <= '0;
				end
				default: begin
					go_q <= go_q;
				end
			endcase
		end
	end

	// frame payload, product and divider registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LOAD: begin
				down_q    <= touch_down;
				pressed_q <= touch_pressed;
				owns_q    <= owns_touch;
				ty_q      <= touch_y;
				dt_q      <= dt_eff;
				gain_q    <= gain_eff;
				maxq_q    <= maxq_eff;
				decay_q   <= DECAY_ROM[idx];
			end
			OP_DRAG_CHK: begin
				delta_q <= delta_c;
				dq_q    <= DQ_W'(delta_c) <<< FRAC_BITS;
			end
			OP_MUL: begin
				mul_p_q   <= MUL_P_W'(mul_a) * MUL_P_W'(mul_b);
				mul_neg_q <= mul_neg;
			end
			OP_RUB_FIN: begin
				dq_q <= rnd_s[DQ_W-1:0];
			end
			OP_DRAG_ADD: begin
				div_rem_q <= '0;
				div_quo_q <= div_init;
				div_neg_q <= delta_q[Y_W];
			end
			OP_DIV_STEP: begin
				div_rem_q <= div_ge ? div_sub[DT_W-1:0] : div_shift[DT_W-1:0];
				div_quo_q <= {div_quo_q[DIV_W-2:0], div_ge};
			end
			default: begin
				dt_q <= dt_q;
			end
		endcase
	end

	// status back to the sequencer
	always_comb begin
		sts.dragging   = dragging_q;
		sts.go_drag    = go_q;
		sts.rubber     = rub_q;
		sts.delta_zero = (delta_q == '0);
		sts.div_last   = (div_cnt_q == '0);
		sts.glide      = (vel_mag > VEL_W'(MIN_SPEED));
		sts.under      = offset_q[OFF_W-1];
		sts.over       = (offset_q > maxq_q);
	end

	assign offset   = offset_q;
	assign velocity = velocity_q;
	assign dragging = dragging_q;

endmodule

### hdl/ks_ctrl.sv
// sequencer of the kinetic scroll engine: steps the datapath through one frame
module ks_ctrl import ks_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    out_free,
	input  ks_sts_t sts,
	output ks_cmd_t cmd,
	output logic    in_ready,
	output logic    out_load
);

	ks_state_t state_q;
	ks_state_t state_d;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and commands
	always_comb begin
		state_d  = state_q;
		cmd.op   = OP_NONE;
		cmd.msel = MSEL_RUB;
		in_ready = 1'b0;
		out_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.op  = OP_LOAD;
					state_d = ST_PRESS;
				end
			end
			ST_PRESS: begin
				cmd.op  = OP_PRESS;
				state_d = ST_DRAG_CHK;
			end
			ST_DRAG_CHK: begin
				cmd.op  = OP_DRAG_CHK;
				state_d = ST_DRAG_SEL;
			end
			ST_DRAG_SEL: begin
				if (!sts.go_drag)
					state_d = ST_GLIDE_CHK;
				else if (sts.rubber)
					state_d = ST_RUB_MUL;
				else
					state_d = ST_DRAG_ADD;
			end
			ST_RUB_MUL: begin
				cmd.op   = OP_MUL;
				cmd.msel = MSEL_RUB;
				state_d  = ST_RUB_FIN;
			end
			ST_RUB_FIN: begin
				cmd.op  = OP_RUB_FIN;
				state_d = ST_DRAG_ADD;
			end
			ST_DRAG_ADD: begin
				cmd.op  = OP_DRAG_ADD;
				state_d = sts.delta_zero ? ST_DONE : ST_DIV;
			end
			ST_DIV: begin
				cmd.op = OP_DIV_STEP;
				if (sts.div_last)
					state_d = ST_DIV_FIN;
			end
			ST_DIV_FIN: begin
				cmd.op  = OP_DIV_FIN;
				state_d = ST_DONE;
			end
			ST_GLIDE_CHK: begin
				if (sts.glide) begin
					state_d = ST_GOFF_MUL;
				end else begin
					cmd.op  = OP_VEL_ZERO;
					state_d = ST_SPR_CHK;
				end
			end
			ST_GOFF_MUL: begin
				cmd.op   = OP_MUL;
				cmd.msel = MSEL_GOFF;
				state_d  = ST_GOFF_FIN;
			end
			ST_GOFF_FIN: begin
				cmd.op  = OP_GLIDE_OFF;
				state_d = ST_GVEL_MUL;
			end
			ST_GVEL_MUL: begin
				cmd.op   = OP_MUL;
				cmd.msel = MSEL_GVEL;
				state_d  = ST_GVEL_FIN;
			end
			ST_GVEL_FIN: begin
				cmd.op  = OP_GLIDE_VEL;
				state_d = ST_SPR_CHK;
			end
			ST_SPR_CHK: begin
				state_d = (sts.under || sts.over) ? ST_SPR_MUL : ST_DONE;
			end
			ST_SPR_MUL: begin
				cmd.op   = OP_MUL;
				cmd.msel = MSEL_SPR;
				state_d  = ST_SPR_FIN;
			end
			ST_SPR_FIN: begin
				cmd.op  = OP_SPR_FIN;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

### hdl/kinetic_scroll_engine.sv
// top level of the kinetic scroll engine: register port, sequencer, datapath, result register
//
// One touch frame enters per input beat (in_valid/in_ready); one result beat
// (out_valid/out_ready) carries the offset, velocity and drag flag after that frame.
// content_height and view_height are written over the APB port at byte addresses 0
// and 4; the user must write them only while the block is idle, which the block
// itself does not enforce. pready is always high. A plain release frame runs the
// press and drag checks, then the glide and spring checks; a glide adds the offset
// and velocity products, the spring its own product, and a moving drag runs the
// one-bit-per-cycle divider that forms delta/dt (after a rubber-band product past
// an edge). A new frame is taken the cycle after the previous result has been
// moved into the output register.
// The glide, rubber-band and spring products share a single multiplier.
// A receiver stall holds the result in the output register; the next frame is
// still accepted and computed, and waits for the output register to free up.
// Reset clears the scroll state and both registers to zero; the decay table
// is a constant and needs no fill.
module kinetic_scroll_engine import ks_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [ADDR_W-1:0]       paddr,
	input  logic [DATA_W-1:0]       pwdata,
	output logic [DATA_W-1:0]       prdata,
	output logic                    pready,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic                    touch_down,
	input  logic                    touch_pressed,
	input  logic [Y_W-1:0]          touch_y,
	input  logic                    owns_touch,
	input  logic [DT_W-1:0]         frame_time,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [OFF_W-1:0] scroll_offset,
	output logic signed [VEL_W-1:0] scroll_velocity,
	output logic                    is_dragging
);

	logic [CFG_W-1:0]        content_height_q;
	logic [CFG_W-1:0]        view_height_q;
	logic                    out_valid_q;
	logic signed [OFF_W-1:0] scroll_offset_q;
	logic signed [VEL_W-1:0] scroll_velocity_q;
	logic                    is_dragging_q;

	ks_cmd_t                 cmd;
	ks_sts_t                 sts;
	logic                    out_free;
	logic                    out_load;
	logic signed [OFF_W-1:0] dp_offset;
	logic signed [VEL_W-1:0] dp_velocity;
	logic                    dp_dragging;

	// register port
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			content_height_q <= '0;
			view_height_q    <= '0;
		end else if (psel && penable && pwrite) begin
			case (paddr[2])
				REG_CONTENT_HEIGHT: content_height_q <= pwdata[CFG_W-1:0];
				REG_VIEW_HEIGHT:    view_height_q    <= pwdata[CFG_W-1:0];
				default:            view_height_q    <= view_height_q;
			endcase
		end
	end

	always_comb begin
		case (paddr[2])
			REG_CONTENT_HEIGHT: prdata = DATA_W'(content_height_q);
			REG_VIEW_HEIGHT:    prdata = DATA_W'(view_height_q);
			default:            prdata = '0;
		endcase
	end

	// sequencer
	ks_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_free (out_free),
		.sts      (sts),
		.cmd      (cmd),
		.in_ready (in_ready),
		.out_load (out_load)
	);

	// datapath
	ks_dp u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.sts            (sts),
		.touch_down     (touch_down),
		.touch_pressed  (touch_pressed),
		.touch_y        (touch_y),
		.owns_touch     (owns_touch),
		.frame_time     (frame_time),
		.content_height (content_height_q),
		.view_height    (view_height_q),
		.offset         (dp_offset),
		.velocity       (dp_velocity),
		.dragging       (dp_dragging)
	);

	// result register
	assign out_free = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			scroll_offset_q   <= dp_offset;
			scroll_velocity_q <= dp_velocity;
			is_dragging_q     <= dp_dragging;
		end
	end

	assign out_valid       = out_valid_q;
	assign scroll_offset   = scroll_offset_q;
	assign scroll_velocity = scroll_velocity_q;
	assign is_dragging     = is_dragging_q;

`ifndef SYNTHESIS
	// a result is never written over one that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> (!out_valid_q || out_ready))
		else $error("result register overwritten while stalled");

	// one frame at a time
	a_one_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("input taken while a frame is in progress");

	// released content above the top edge has been stopped by the spring
	a_spring_stops: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !is_dragging && scroll_offset[OFF_W-1]) |-> (scroll_velocity == '0))
		else $error("velocity left nonzero past the edge after release");
`endif

endmodule
